>>> design/idle_timeout_frame_checker_defines.svh
// assertion macros for the idle timeout frame checker
// no dependencies; included by the top level only
`ifndef IDLE_TIMEOUT_FRAME_CHECKER_DEFINES_SVH
`define IDLE_TIMEOUT_FRAME_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ITFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itfc implication check failed");
// next-cycle implication, checked out of reset
`define ITFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itfc next-cycle check failed");
`else
`define ITFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ITFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/itfc_pkg.sv
// shared types and constants of the idle timeout frame checker
// no dependencies
`default_nettype none

package itfc_pkg;

    // result status codes
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_LENGTH   = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd0;
    localparam logic [1:0] REG_CHECKSUM_SEED   = 2'd1;
    localparam logic [1:0] REG_IDLE_TICKS      = 2'd2;

    // configuration reset values
    localparam logic [5:0] EXPECTED_LENGTH_RESET = 6'd23;
    localparam logic [7:0] CHECKSUM_SEED_RESET   = 8'h58;
    localparam logic [7:0] IDLE_TICKS_RESET      = 8'd50;

    // longest frame that the result fields can carry
    localparam int unsigned MAX_FRAME = 32;

    // input function codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept_byte;
        logic accept_tick;
        logic load_err;
        logic load_byte;
        logic clear_frame;
        logic idx_inc;
    } itfc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_closes;
        logic len_bad;
        logic sum_bad;
        logic is_last;
        logic out_free;
        logic empty;
    } itfc_stat_t;

endpackage

`default_nettype wire

>>> design/itfc_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module itfc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/itfc_ctrl.sv
// controller state machine: input acceptance, frame close and readout sequencing
// depends on itfc_pkg
`default_nettype none

module itfc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               func,
    output logic                    in_ready,
    input  wire itfc_pkg::itfc_stat_t stat,
    output itfc_pkg::itfc_cmd_t     cmd
);

    import itfc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept_byte = in_fire && (func == FUNC_BYTE);
        cmd.accept_tick = in_fire && (func == FUNC_TICK);
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept_tick && stat.tick_closes)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (stat.len_bad || stat.sum_bad)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_err    = 1'b1;
                        cmd.clear_frame = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (stat.is_last)
                    begin
                        cmd.clear_frame = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/itfc_datapath.sv
// datapath: config registers, frame store, idle timer, running sums, result register
// depends on itfc_pkg and itfc_ram
`default_nettype none

module itfc_datapath #(
    parameter int unsigned BUFFER_DEPTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_fire,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 out_ready,
    input  wire itfc_pkg::itfc_cmd_t  cmd,
    output itfc_pkg::itfc_stat_t      stat,
    output logic                      out_valid,
    output logic [1:0]                status,
    output logic [7:0]                frame_byte,
    output logic [4:0]                byte_index,
    output logic                      last
);

    import itfc_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned LW = (CW > 6) ? CW : 6;

    logic [5:0]    expected_length_reg;
    logic [7:0]    checksum_seed_reg;
    logic [7:0]    idle_ticks_reg;

    logic [CW-1:0] count_reg;
    logic          overflow_reg;
    logic [7:0]    idle_left_reg;
    logic          armed_reg;
    logic [7:0]    total_sum_reg;
    logic [7:0]    prev_sum_reg;
    logic [7:0]    last_byte_reg;
    logic [AW-1:0] idx_reg;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [7:0]    frame_byte_reg;
    logic [4:0]    byte_index_reg;
    logic          last_reg;

    logic          full;
    logic          wr_en;
    logic [7:0]    rd_data;
    logic [7:0]    check_byte;
    logic [LW-1:0] count_ext;

    assign full       = (count_reg == CW'(BUFFER_DEPTH));
    assign wr_en      = cmd.accept_byte && !full;
    assign check_byte = ~(checksum_seed_reg + prev_sum_reg);
    assign count_ext  = LW'(count_reg);

    itfc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        stat.tick_closes = armed_reg && (idle_left_reg <= 8'd1);
        stat.len_bad     = overflow_reg || (count_reg == '0)
                           || (count_ext != LW'(expected_length_reg))
                           || (count_ext > LW'(MAX_FRAME));
        stat.sum_bad     = (last_byte_reg != check_byte);
        stat.is_last     = ((CW'(idx_reg) + CW'(1)) == count_reg);
        stat.out_free    = !out_valid_reg || out_ready;
        stat.empty       = (count_reg == '0) && !overflow_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_length_reg <= EXPECTED_LENGTH_RESET;
            checksum_seed_reg   <= CHECKSUM_SEED_RESET;
            idle_ticks_reg      <= IDLE_TICKS_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_EXPECTED_LENGTH: expected_length_reg <= cfg_data[5:0];
                REG_CHECKSUM_SEED:   checksum_seed_reg   <= cfg_data;
                REG_IDLE_TICKS:      idle_ticks_reg      <= cfg_data;
                default:             ;
            endcase
        end
    end

    // frame bookkeeping and idle timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            idle_left_reg <= '0;
            armed_reg     <= 1'b0;
            total_sum_reg <= '0;
            prev_sum_reg  <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cmd.accept_byte)
            begin
                idle_left_reg <= idle_ticks_reg;
                armed_reg     <= 1'b1;
                if (full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg     <= count_reg + CW'(1);
                    prev_sum_reg  <= total_sum_reg;
                    total_sum_reg <= total_sum_reg + rx_byte;
                end
            end
            else if (cmd.accept_tick && armed_reg)
            begin
                if (idle_left_reg > 8'd1)
                begin
                    idle_left_reg <= idle_left_reg - 8'd1;
                end
                else
                begin
                    idle_left_reg <= '0;
                    armed_reg     <= 1'b0;
                end
            end
            if (cmd.clear_frame)
            begin
                count_reg     <= '0;
                overflow_reg  <= 1'b0;
                total_sum_reg <= '0;
                prev_sum_reg  <= '0;
                idx_reg       <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // last byte held aside so the check needs no store read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            last_byte_reg <= rx_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_err || cmd.load_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            status_reg     <= stat.len_bad ? STATUS_LENGTH : STATUS_CHECKSUM;
            frame_byte_reg <= '0;
            byte_index_reg <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            status_reg     <= STATUS_GOOD;
            frame_byte_reg <= rd_data;
            byte_index_reg <= 5'(idx_reg);
            last_reg       <= stat.is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign frame_byte = frame_byte_reg;
    assign byte_index = byte_index_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

>>> design/idle_timeout_frame_checker.sv
// top level of the idle timeout frame checker
// depends on itfc_pkg, itfc_ctrl, itfc_datapath and the assertion macro header
`default_nettype none

`include "idle_timeout_frame_checker_defines.svh"

// Receives bytes (func 0) and timer ticks (func 1) on the input channel. each byte is
// stored and restarts an idle timer loaded from idle_ticks; when the ticks run it out the
// held frame is checked: its length must equal expected_length (and fit the store), and its
// final byte must be the inverse of the low byte of checksum_seed plus all earlier bytes.
// a good frame comes out as one transfer per byte with last on the final one; a bad frame
// gives a single transfer with status set, zero data and last high. either way the store is
// emptied. bytes beyond BUFFER_DEPTH are dropped and the frame reports a wrong length.
// flow: a byte, or a tick that does not close a frame, is taken at once and the next item
// can follow straight away. a closing tick takes the block out of accepting input until the
// frame is dealt with: an error frame needs only the close state, a good frame the close
// state and then a read and an emit state per byte, as every byte is read from the store
// with a registered read before reaching the output register. output stalls add to this.
// the output register lets the final result wait while new bytes are already taken. no
// clearing pass runs after reset. configuration writes are always taken.
module idle_timeout_frame_checker #(
    parameter int unsigned BUFFER_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // input channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       func,
    input  wire logic [7:0] rx_byte,
    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [7:0]      frame_byte,
    output logic [4:0]      byte_index,
    output logic            last
);

    import itfc_pkg::*;

    itfc_cmd_t  cmd;
    itfc_stat_t stat;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencing: accept, close, read out
    itfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, timer, checks and result register
    itfc_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_fire   (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .status     (status),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last       (last)
    );

    // an error transfer is always the single, final one of its frame
    `ITFC_ASSERT_IMPLY(a_err_shape, clk, rst_n, out_valid && (status != STATUS_GOOD), last && (frame_byte == 8'd0) && (byte_index == 5'd0))
    // a result is only loaded when the previous one has gone or is going
    `ITFC_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.load_err || cmd.load_byte, stat.out_free)
    // closing a frame leaves the store empty
    `ITFC_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear_frame, stat.empty)

endmodule

`default_nettype wire
